### hdl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the barometric pressure compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

   localparam int RAW_W       = 10;
   localparam int COEFF_W     = 16;
   localparam int CROSS_W     = 14;
   localparam int HPA_W       = 11;
   localparam int CSR_INDEX_W = 2;

   // compensated sum at 2^-22 scale, one guard bit over the 37 bits needed
   localparam int SUM_W       = 38;
   // sum times the 17-bit signed scale factor
   localparam int PROD_W      = SUM_W + 17;
   localparam int OUT_SHIFT   = 38;
   localparam int QUOT_W      = PROD_W - OUT_SHIFT;

   localparam logic [16:0]         SCALE_MUL = 17'd41641;
   localparam logic signed [17:0]  HPA_BIAS  = 18'sd500;
   localparam logic signed [17:0]  HPA_MAX   = 18'sd2047;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OFFSET = 2'd0,
      CSR_SLOPE  = 2'd1,
      CSR_TEMP   = 2'd2,
      CSR_CROSS  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [COEFF_W-1:0] a0;
      logic signed [COEFF_W-1:0] b1;
      logic signed [COEFF_W-1:0] b2;
      logic signed [CROSS_W-1:0] c12;
   } coeff_type;

endpackage

### hdl/bpc_csr.sv
// ----------------------------------------------------------------------------
// bpc_csr
// Calibration coefficient registers, written through the csr port.
// ----------------------------------------------------------------------------
module bpc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [bpc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bpc_pkg::COEFF_W-1:0]        csr_wdata,
   output bpc_pkg::coeff_type                 coeff
);
   import bpc_pkg::*;

   coeff_type coeff_ff;
   coeff_type coeff_in;

   always_comb begin
      coeff_in = coeff_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_OFFSET: coeff_in.a0  = $signed(csr_wdata);
            CSR_SLOPE:  coeff_in.b1  = $signed(csr_wdata);
            CSR_TEMP:   coeff_in.b2  = $signed(csr_wdata);
            CSR_CROSS:  coeff_in.c12 = $signed(csr_wdata[CROSS_W-1:0]);
            default:    coeff_in = coeff_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
      end else begin
         coeff_ff <= coeff_in;
      end
   end

   assign coeff = coeff_ff;

endmodule

### hdl/bpc_poly.sv
// ----------------------------------------------------------------------------
// bpc_poly
// Three-stage pipeline forming a0<<19 + b1*P<<9 + c12*T*P + b2*T<<8.
// ----------------------------------------------------------------------------
module bpc_poly (
   input  logic                                clock,
   input  logic                                reset,
   input  bpc_pkg::coeff_type                  coeff,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [bpc_pkg::RAW_W-1:0]           in_pressure,
   input  logic [bpc_pkg::RAW_W-1:0]           in_temperature,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [bpc_pkg::SUM_W-1:0]    out_sum
);
   import bpc_pkg::*;

   localparam int CT_W  = CROSS_W + RAW_W + 1;
   localparam int LIN_W = COEFF_W + RAW_W + 1;
   localparam int CTP_W = CT_W + RAW_W + 1;

   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   // stage 1: single products
   logic [RAW_W-1:0]        p1_ff;
   logic signed [CT_W-1:0]  ct_ff,  ct_in;
   logic signed [LIN_W-1:0] bp_ff,  bp_in;
   logic signed [LIN_W-1:0] bt_ff,  bt_in;

   // stage 2: cross product and linear sum
   logic signed [CTP_W-1:0] ctp_ff, ctp_in;
   logic signed [SUM_W-1:0] lin_ff, lin_in;

   // stage 3: full sum
   logic signed [SUM_W-1:0] sum_ff, sum_in;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      ct_in  = coeff.c12 * $signed({1'b0, in_temperature});
      bp_in  = coeff.b1  * $signed({1'b0, in_pressure});
      bt_in  = coeff.b2  * $signed({1'b0, in_temperature});
      ctp_in = ct_ff * $signed({1'b0, p1_ff});
      lin_in = $signed({{(SUM_W-COEFF_W-19){coeff.a0[COEFF_W-1]}}, coeff.a0, 19'd0})
             + $signed({{(SUM_W-LIN_W-9){bp_ff[LIN_W-1]}}, bp_ff, 9'd0})
             + $signed({{(SUM_W-LIN_W-8){bt_ff[LIN_W-1]}}, bt_ff, 8'd0});
      sum_in = lin_ff + $signed({{(SUM_W-CTP_W){ctp_ff[CTP_W-1]}}, ctp_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         p1_ff <= in_pressure;
         ct_ff <= ct_in;
         bp_ff <= bp_in;
         bt_ff <= bt_in;
      end
      if (rdy2) begin
         ctp_ff <= ctp_in;
         lin_ff <= lin_in;
      end
      if (rdy3) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_sum   = sum_ff;

endmodule

### hdl/bpc_scale.sv
// ----------------------------------------------------------------------------
// bpc_scale
// Two-stage pipeline: scale to hPa, floor, add bias and saturate.
// ----------------------------------------------------------------------------
module bpc_scale (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [bpc_pkg::SUM_W-1:0]    in_sum,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [bpc_pkg::HPA_W-1:0]           out_hpa
);
   import bpc_pkg::*;

   logic v4_ff, v5_ff;
   logic rdy4, rdy5;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [QUOT_W-1:0] quot;
   logic signed [17:0]       biased;
   logic [HPA_W-1:0]         hpa_ff, hpa_in;

   assign rdy5     = !v5_ff || out_ready;
   assign rdy4     = !v4_ff || rdy5;
   assign in_ready = rdy4;

   always_comb begin
      prod_in = in_sum * $signed(SCALE_MUL);
      // arithmetic shift gives the floor
      quot    = prod_ff[PROD_W-1:OUT_SHIFT];
      biased  = $signed({quot[QUOT_W-1], quot}) + HPA_BIAS;
      if (biased < 0) begin
         hpa_in = '0;
      end else if (biased > HPA_MAX) begin
         hpa_in = HPA_MAX[HPA_W-1:0];
      end else begin
         hpa_in = biased[HPA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy4) begin
            v4_ff <= in_valid;
         end
         if (rdy5) begin
            v5_ff <= v4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         prod_ff <= prod_in;
      end
      if (rdy5) begin
         hpa_ff <= hpa_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_hpa   = hpa_ff;

endmodule

### hdl/barometric_pressure_compensation.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Turns a raw 10-bit pressure and temperature pair into compensated hPa.
// ----------------------------------------------------------------------------
// One beat is accepted per clock while the output is not stalled, and result
// beats leave in the order of acceptance. The five stages are the coefficient
// products, the cross product with the linear sum, the final add, the scale
// multiply and the floor/bias/saturate output register; each stage holds its
// beat while the stage after it is full, so a stall on rsp_ backs up without
// loss. Coefficients are written through csr_ and take effect on the next
// clock; change them only while no beat is in flight.
module barometric_pressure_compensation (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [bpc_pkg::RAW_W-1:0]          req_raw_pressure,
   input  logic [bpc_pkg::RAW_W-1:0]          req_raw_temperature,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bpc_pkg::HPA_W-1:0]          rsp_pressure_hpa,
   input  logic                               csr_write,
   input  logic [bpc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bpc_pkg::COEFF_W-1:0]        csr_wdata
);
   import bpc_pkg::*;

   coeff_type               coeff;
   logic                    sum_valid;
   logic                    sum_ready;
   logic signed [SUM_W-1:0] sum;

   bpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coeff     (coeff)
   );

   bpc_poly u_poly (
      .clock          (clock),
      .reset          (reset),
      .coeff          (coeff),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .in_pressure    (req_raw_pressure),
      .in_temperature (req_raw_temperature),
      .out_valid      (sum_valid),
      .out_ready      (sum_ready),
      .out_sum        (sum)
   );

   bpc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_sum    (sum),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_hpa   (rsp_pressure_hpa)
   );

   // a free output never holds up the input
   a_flow_through: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output is free");

   // backpressure on the input only with a full output register
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty output");

   // the inner sum holds while the scale stages are full
   a_sum_hold: assert property (@(posedge clock) disable iff (reset)
      sum_valid && !sum_ready |=> sum_valid && $stable(sum))
      else $error("inner sum lost under stall");

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for barometric_pressure_compensation. A local integer
// predictor computes the compensated hPa for every accepted request beat from
// its own copy of the four coefficients. A scoreboard compares each response
// beat in order. Directed tests cover reset defaults, both saturation rails,
// floor rounding of negative sums and masking of the cross coefficient. Random
// phases use realistic and arbitrary coefficients; two run without backpressure.
// ----------------------------------------------------------------------------
module tb_top;
   import bpc_pkg::*;

   localparam int  HPA_SCALE   = 41641;
   localparam int  HPA_OFFSET  = 500;
   localparam int  HPA_CEIL    = 2047;
   localparam int  QUOT_SHIFT  = 38;
   localparam int  LONG_HOLD   = 150;

   typedef struct {
      logic [RAW_W-1:0] pressure;
      logic [RAW_W-1:0] temperature;
      logic [HPA_W-1:0] hpa;
   } hpa_entry_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [RAW_W-1:0]       req_raw_pressure;
   logic [RAW_W-1:0]       req_raw_temperature;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [HPA_W-1:0]       rsp_pressure_hpa;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [COEFF_W-1:0]     csr_wdata;

   // coefficient copy used by the predictor
   logic signed [COEFF_W-1:0] a0_c;
   logic signed [COEFF_W-1:0] b1_c;
   logic signed [COEFF_W-1:0] b2_c;
   logic signed [CROSS_W-1:0] c12_c;

   hpa_entry_type hpa_expected[$];
   int         beats_sent;
   int         beats_checked;
   int         mismatch_count;
   int         low_rail_count;
   int         high_rail_count;
   int         coeff_sets;
   bit         gaps_on;
   bit         stalls_on;
   int         rsp_hold_cycles;

   barometric_pressure_compensation u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_raw_pressure    (req_raw_pressure),
      .req_raw_temperature (req_raw_temperature),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pressure_hpa    (rsp_pressure_hpa),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("%0t: timeout, %0d beats still outstanding", $time, hpa_expected.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [HPA_W-1:0] compensate_hpa(input logic [RAW_W-1:0] p,
                                                       input logic [RAW_W-1:0] t);
      longint sum;
      longint hpa;
      sum = (longint'(a0_c) <<< 19)
          + (longint'(b1_c) * longint'(p) <<< 9)
          + longint'(c12_c) * longint'(t) * longint'(p)
          + (longint'(b2_c) * longint'(t) <<< 8);
      hpa = ((sum * HPA_SCALE) >>> QUOT_SHIFT) + HPA_OFFSET;
      if (hpa < 0) hpa = 0;
      if (hpa > HPA_CEIL) hpa = HPA_CEIL;
      return hpa[HPA_W-1:0];
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [COEFF_W-1:0] pick_coeff();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4: return 16'h0001;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [RAW_W-1:0] pick_raw();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return RAW_W'($urandom);
      endcase
   endfunction

   // response side: random stalls, or one long hold when a test asks for it
   initial begin : rsp_driver
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end else if (stalls_on && $urandom_range(0, 99) < 30) begin
            n = pick_gap();
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : scoreboard
      hpa_entry_type e;
      if (!reset) begin
         if (req_valid && req_ready) begin
            e.pressure    = req_raw_pressure;
            e.temperature = req_raw_temperature;
            e.hpa         = compensate_hpa(req_raw_pressure, req_raw_temperature);
            hpa_expected.push_back(e);
         end
         if (rsp_valid && rsp_ready) begin
            if (hpa_expected.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual pressure_hpa %0d",
                        $time, rsp_pressure_hpa);
               mismatch_count++;
            end else begin
               e = hpa_expected.pop_front();
               beats_checked++;
               if (rsp_pressure_hpa !== e.hpa) begin
                  $display("%0t: pressure_hpa for P=%0d T=%0d expected %0d actual %0d",
                           $time, e.pressure, e.temperature, e.hpa, rsp_pressure_hpa);
                  mismatch_count++;
               end
               if (rsp_pressure_hpa == 0) low_rail_count++;
               if (rsp_pressure_hpa == HPA_CEIL) high_rail_count++;
            end
         end
      end
   end

   task automatic send_sample(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
      int gap;
      @(negedge clock);
      req_valid           <= 1'b1;
      req_raw_pressure    <= p;
      req_raw_temperature <= t;
      do @(posedge clock); while (!(req_valid && req_ready));
      beats_sent++;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (hpa_expected.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_coeff(input csr_index_type idx, input logic [COEFF_W-1:0] v);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_OFFSET: a0_c  = v;
         CSR_SLOPE:  b1_c  = v;
         CSR_TEMP:   b2_c  = v;
         CSR_CROSS:  c12_c = v[CROSS_W-1:0];
         default:    ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic load_coeffs(input logic [COEFF_W-1:0] a0, input logic [COEFF_W-1:0] b1,
                              input logic [COEFF_W-1:0] b2, input logic [COEFF_W-1:0] c12);
      wait_idle();
      write_coeff(CSR_OFFSET, a0);
      write_coeff(CSR_SLOPE, b1);
      write_coeff(CSR_TEMP, b2);
      write_coeff(CSR_CROSS, c12);
      coeff_sets++;
   endtask

   task automatic test_reset_defaults();
      send_sample(10'd0, 10'd0);
      send_sample(10'd1023, 10'd1023);
      send_sample(10'h2AA, 10'h155);
   endtask

   task automatic test_saturation();
      load_coeffs(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h1FFF);
      send_sample(10'd1023, 10'd1023);
      send_sample(10'd0, 10'd0);
      // upper bits of the cross write must be dropped
      load_coeffs(16'h8000, 16'h8000, 16'h8000, 16'hE000);
      send_sample(10'd1023, 10'd1023);
      send_sample(10'd0, 10'd0);
      send_sample(10'd1, 10'd1);
   endtask

   task automatic test_floor_rounding();
      load_coeffs(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
      send_sample(10'd0, 10'd0);
      load_coeffs(16'h0001, 16'h0000, 16'h0000, 16'h0000);
      send_sample(10'd0, 10'd0);
      load_coeffs(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      send_sample(10'd1023, 10'd1023);
   endtask

   task automatic test_typical_coeffs();
      load_coeffs(16'h3ECE, 16'hB3F9, 16'hC517, 16'h0CF1);
      send_sample(10'd410, 10'd510);
      send_sample(10'd0, 10'd1023);
      send_sample(10'd1023, 10'd0);
      send_sample(10'd512, 10'd512);
      send_sample(10'h155, 10'h2AA);
   endtask

   task automatic test_backpressure();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      load_coeffs(16'h3C00, -16'sd20000, -16'sd15000, 16'd3000);
      rsp_hold_cycles = LONG_HOLD;
      repeat (40) send_sample(RAW_W'($urandom), RAW_W'($urandom));
      // sender pauses here until the pipeline has fully drained
      wait_idle();
   endtask

   task automatic test_random_phases();
      int phase;
      int k;
      for (phase = 0; phase < 8; phase++) begin
         gaps_on   = (phase % 3) != 2;
         stalls_on = (phase % 3) != 2;
         if (phase % 2 == 0) begin
            load_coeffs(16'($urandom_range(12000, 20000)),
                        16'(-$urandom_range(14000, 24000)),
                        16'(-$urandom_range(12000, 18000)),
                        {2'($urandom_range(0, 3)), 14'($urandom_range(0, 8191))});
         end else begin
            load_coeffs(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff());
         end
         for (k = 0; k < 250; k++) send_sample(pick_raw(), pick_raw());
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_raw_pressure    = '0;
      req_raw_temperature = '0;
      csr_write           = 1'b0;
      csr_index           = CSR_OFFSET;
      csr_wdata           = '0;
      a0_c                = '0;
      b1_c                = '0;
      b2_c                = '0;
      c12_c               = '0;
      beats_sent          = 0;
      beats_checked       = 0;
      mismatch_count      = 0;
      low_rail_count      = 0;
      high_rail_count     = 0;
      coeff_sets          = 1;
      gaps_on             = 1'b1;
      stalls_on           = 1'b1;
      rsp_hold_cycles     = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_saturation();
      test_floor_rounding();
      test_typical_coeffs();
      test_backpressure();
      test_random_phases();
      wait_idle();

      $display("covered %0d request beats, %0d responses checked, %0d coefficient sets",
               beats_sent, beats_checked, coeff_sets);
      $display("responses at low rail %0d, at high rail %0d", low_rail_count,
               high_rail_count);
      if (mismatch_count == 0 && hpa_expected.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
